// ===== rtl/quaternion_product_and_rotate_core_macros.svh =====
// assertion macros for the quaternion core rtl, included by qpr_hamilton
`ifndef QUATERNION_PRODUCT_AND_ROTATE_CORE_MACROS_SVH
`define QUATERNION_PRODUCT_AND_ROTATE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define QPR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qpr assertion failed");

// next-cycle implication, disabled during reset
`define QPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qpr assertion failed");

`endif

// ===== rtl/qpr_pkg.sv =====
// shared types, constants and helpers for the quaternion core
package qpr_pkg;

  localparam int DATA_W = 32;

  // command codes
  localparam logic CMD_PRODUCT = 1'b0;
  localparam logic CMD_ROTATE  = 1'b1;

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] w;
  } quat_t;

  // negate with the most negative value clamped to the maximum
  function automatic logic signed [DATA_W-1:0] neg_sat(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] res;
    if (v == Q_MIN) begin
      res = Q_MAX;
    end else begin
      res = -v;
    end
    return res;
  endfunction

endpackage

// ===== rtl/qpr_in_if.sv =====
// operand channel: command and two quaternions with valid/ready
interface qpr_in_if;
  import qpr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [DATA_W-1:0] q_x;
  logic signed [DATA_W-1:0] q_y;
  logic signed [DATA_W-1:0] q_z;
  logic signed [DATA_W-1:0] q_w;
  logic signed [DATA_W-1:0] p_x;
  logic signed [DATA_W-1:0] p_y;
  logic signed [DATA_W-1:0] p_z;
  logic signed [DATA_W-1:0] p_w;

  modport source (
    output valid, command, q_x, q_y, q_z, q_w, p_x, p_y, p_z, p_w,
    input  ready
  );

  modport sink (
    input  valid, command, q_x, q_y, q_z, q_w, p_x, p_y, p_z, p_w,
    output ready
  );

endinterface

// ===== rtl/qpr_out_if.sv =====
// result channel: one quaternion with valid/ready
interface qpr_out_if;
  import qpr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] r_x;
  logic signed [DATA_W-1:0] r_y;
  logic signed [DATA_W-1:0] r_z;
  logic signed [DATA_W-1:0] r_w;

  modport source (
    output valid, r_x, r_y, r_z, r_w,
    input  ready
  );

  modport sink (
    input  valid, r_x, r_y, r_z, r_w,
    output ready
  );

endinterface

// ===== rtl/quaternion_product_and_rotate_core.sv =====
// Quaternion product and vector rotation core, signed fixed point with FRAC_BITS fraction
// bits. command 0 returns the Hamilton product q*p; command 1 returns the xyz part of
// q*(p.xyz, 1.0)*conj(q) with r_w forced to zero (a non-unit q scales the result by its
// squared norm). Each component product is truncated by an arithmetic shift and each
// four-term sum saturates to 32 bits. The core takes one transaction per clock while the
// result channel is not stalled, and returns each result through two chained Hamilton
// units, each a stage of sixteen 32x32 multipliers followed by a stage of adders and
// saturation, with the last stage doubling as the output register. A product-mode item
// passes the second unit multiplied by the identity quaternion, which leaves it unchanged.
module quaternion_product_and_rotate_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  qpr_in_if.sink    operand,
  qpr_out_if.source result
);
  import qpr_pkg::*;

  localparam logic signed [DATA_W-1:0] ONE_Q = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam int SIDE1_W = 1 + $bits(quat_t);

  logic   rotate;
  quat_t  q;
  quat_t  p_lift;
  quat_t  b2;
  quat_t  t;
  quat_t  r2;
  logic   [SIDE1_W-1:0] side1_in;
  logic   [SIDE1_W-1:0] side1_out;
  logic   u1_valid;
  logic   u2_ready;
  logic   cmd_out;

  assign rotate = (operand.command == CMD_ROTATE);

  // first operand, and second with the scalar lifted to 1.0 when rotating
  assign q.x      = operand.q_x;
  assign q.y      = operand.q_y;
  assign q.z      = operand.q_z;
  assign q.w      = operand.q_w;
  assign p_lift.x = operand.p_x;
  assign p_lift.y = operand.p_y;
  assign p_lift.z = operand.p_z;
  assign p_lift.w = rotate ? ONE_Q : operand.p_w;

  // right factor for the second unit: conj(q) or identity
  always_comb begin
    if (rotate) begin
      b2.x = neg_sat(operand.q_x);
      b2.y = neg_sat(operand.q_y);
      b2.z = neg_sat(operand.q_z);
      b2.w = operand.q_w;
    end else begin
      b2.x = '0;
      b2.y = '0;
      b2.z = '0;
      b2.w = ONE_Q;
    end
  end

  assign side1_in = {operand.command, b2};

  // first unit: q * p
  qpr_hamilton #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (SIDE1_W)
  ) u_ham_first (
    .clk      (clk),
    .rst      (rst),
    .up_valid (operand.valid),
    .up_ready (operand.ready),
    .a        (q),
    .b        (p_lift),
    .up_side  (side1_in),
    .dn_valid (u1_valid),
    .dn_ready (u2_ready),
    .r        (t),
    .dn_side  (side1_out)
  );

  // second unit: t * conj(q) or t * identity
  qpr_hamilton #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (1)
  ) u_ham_second (
    .clk      (clk),
    .rst      (rst),
    .up_valid (u1_valid),
    .up_ready (u2_ready),
    .a        (t),
    .b        (side1_out[$bits(quat_t)-1:0]),
    .up_side  (side1_out[SIDE1_W-1]),
    .dn_valid (result.valid),
    .dn_ready (result.ready),
    .r        (r2),
    .dn_side  (cmd_out)
  );

  // rotation drops the scalar
  assign result.r_x = r2.x;
  assign result.r_y = r2.y;
  assign result.r_z = r2.z;
  assign result.r_w = (cmd_out == CMD_ROTATE) ? '0 : r2.w;

endmodule

// ===== rtl/qpr_hamilton.sv =====
// two-stage pipelined saturating fixed-point hamilton product a*b
`include "quaternion_product_and_rotate_core_macros.svh"

module qpr_hamilton #(
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  qpr_pkg::quat_t      a,
  input  qpr_pkg::quat_t      b,
  input  logic [SIDE_W-1:0]   up_side,
  output logic                dn_valid,
  input  logic                dn_ready,
  output qpr_pkg::quat_t      r,
  output logic [SIDE_W-1:0]   dn_side
);
  import qpr_pkg::*;

  localparam int PROD_W  = 2 * DATA_W;
  localparam int TRUNC_W = PROD_W - FRAC_BITS;
  localparam int SUM_W   = TRUNC_W + 2;

  logic signed [DATA_W-1:0]  a_c [4];
  logic signed [DATA_W-1:0]  b_c [4];
  logic signed [PROD_W-1:0]  prod_full [4][4];
  logic signed [TRUNC_W-1:0] prod_next [4][4];
  logic signed [TRUNC_W-1:0] prod [4][4];
  logic signed [SUM_W-1:0]   sum [4];
  quat_t                     r_next;

  logic              s1_valid;
  logic              s1_ready;
  logic [SIDE_W-1:0] s1_side;
  logic              s2_valid;
  logic              s2_ready;
  logic [SIDE_W-1:0] s2_side;
  quat_t             s2_r;

  // component order x, y, z, w
  assign a_c[0] = a.x;
  assign a_c[1] = a.y;
  assign a_c[2] = a.z;
  assign a_c[3] = a.w;
  assign b_c[0] = b.x;
  assign b_c[1] = b.y;
  assign b_c[2] = b.z;
  assign b_c[3] = b.w;

  // bubble-collapsing ready chain
  assign s2_ready = !s2_valid || dn_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign up_ready = s1_ready;

  // all sixteen cross products, truncated toward minus infinity
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_full[i][j] = PROD_W'(a_c[i]) * PROD_W'(b_c[j]);
        prod_next[i][j] = prod_full[i][j][PROD_W-1:FRAC_BITS];
      end
    end
  end

  // stage 1: product registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && s1_ready) begin
      prod    <= prod_next;
      s1_side <= up_side;
    end
  end

  // four-term sums of the hamilton product
  always_comb begin
    sum[0] = SUM_W'(prod[0][3]) + SUM_W'(prod[3][0]) - SUM_W'(prod[2][1]) + SUM_W'(prod[1][2]);
    sum[1] = SUM_W'(prod[1][3]) + SUM_W'(prod[2][0]) + SUM_W'(prod[3][1]) - SUM_W'(prod[0][2]);
    sum[2] = SUM_W'(prod[2][3]) - SUM_W'(prod[1][0]) + SUM_W'(prod[0][1]) + SUM_W'(prod[3][2]);
    sum[3] = SUM_W'(prod[3][3]) - SUM_W'(prod[0][0]) - SUM_W'(prod[1][1]) - SUM_W'(prod[2][2]);
  end

  // clamp to the 32-bit signed range
  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-DATA_W:0]    hi;
    logic signed [DATA_W-1:0] res;
    hi = v[SUM_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      res = v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      res = Q_MIN;
    end else begin
      res = Q_MAX;
    end
    return res;
  endfunction

  always_comb begin
    r_next.x = sat_sum(sum[0]);
    r_next.y = sat_sum(sum[1]);
    r_next.z = sat_sum(sum[2]);
    r_next.w = sat_sum(sum[3]);
  end

  // stage 2: saturated result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_r    <= r_next;
      s2_side <= s1_side;
    end
  end

  assign dn_valid = s2_valid;
  assign r        = s2_r;
  assign dn_side  = s2_side;

  // an accepted transaction lands in the product stage
  `QPR_ASSERT_NEXT(a_accept_fills_s1, clk, rst, up_valid && up_ready, s1_valid)
  // a product-stage item that may advance reaches the sum stage
  `QPR_ASSERT_NEXT(a_s1_moves_to_s2, clk, rst, s1_valid && s2_ready, s2_valid)
  // sideband travels unchanged with its item
  `QPR_ASSERT_NEXT(a_side_follows, clk, rst, s1_valid && s2_ready, dn_side == $past(s1_side))

endmodule

// ===== dv/quaternion_result_checker.sv =====
// result checker for the quaternion core: predicts each result and compares it field by field
`timescale 1ns / 100ps

module quaternion_result_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  qpr_in_if    operand,
  qpr_out_if   result,
  output int   mismatches,
  output int   in_flight
);
  import qpr_pkg::*;

  localparam logic signed [DATA_W-1:0] FIXED_ONE = DATA_W'(1) << FRAC_BITS;

  quat_t pending_results[$];
  int    fail_count = 0;

  assign mismatches = fail_count;

  // clamp a wide sum into the signed word range
  function automatic logic signed [DATA_W-1:0] clamp_word(input longint v);
    logic signed [DATA_W-1:0] res;
    if (v > longint'(Q_MAX)) begin
      res = Q_MAX;
    end else if (v < longint'(Q_MIN)) begin
      res = Q_MIN;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

  // exact product, then arithmetic shift drops the fraction (floor)
  function automatic longint fixed_mul(input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b);
    longint wa, wb;
    wa = a;
    wb = b;
    return (wa * wb) >>> FRAC_BITS;
  endfunction

  // hamilton product a*b, each component saturated
  function automatic quat_t quat_mul(input quat_t a, input quat_t b);
    quat_t r;
    r.x = clamp_word(fixed_mul(a.x, b.w) + fixed_mul(a.w, b.x)
                     - fixed_mul(a.z, b.y) + fixed_mul(a.y, b.z));
    r.y = clamp_word(fixed_mul(a.y, b.w) + fixed_mul(a.z, b.x)
                     + fixed_mul(a.w, b.y) - fixed_mul(a.x, b.z));
    r.z = clamp_word(fixed_mul(a.z, b.w) - fixed_mul(a.y, b.x)
                     + fixed_mul(a.x, b.y) + fixed_mul(a.w, b.z));
    r.w = clamp_word(fixed_mul(a.w, b.w) - fixed_mul(a.x, b.x)
                     - fixed_mul(a.y, b.y) - fixed_mul(a.z, b.z));
    return r;
  endfunction

  // product, or rotation q*(v,1.0)*conj(q) with the scalar dropped
  function automatic quat_t predict_result(input logic cmd, input quat_t q, input quat_t p);
    quat_t lifted, partial, conj, r;
    if (cmd == CMD_PRODUCT) begin
      r = quat_mul(q, p);
    end else begin
      lifted   = p;
      lifted.w = FIXED_ONE;
      partial  = quat_mul(q, lifted);
      // negating the most negative component clamps to the maximum
      conj.x = clamp_word(-longint'(q.x));
      conj.y = clamp_word(-longint'(q.y));
      conj.z = clamp_word(-longint'(q.z));
      conj.w = q.w;
      r      = quat_mul(partial, conj);
      r.w    = '0;
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic signed [DATA_W-1:0] want,
                               input logic signed [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d (0x%08h) actual %0d (0x%08h)",
               $time, name, want, want, got, got);
      fail_count++;
    end
  endtask

  // score completed result transactions, then queue predictions for new operands
  always @(posedge clk) begin
    quat_t got, want;
    if (rst) begin
      pending_results.delete();
      in_flight <= 0;
    end else begin
      if (result.valid && result.ready) begin
        got = {result.r_x, result.r_y, result.r_z, result.r_w};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual x=%0d y=%0d z=%0d w=%0d",
                   $time, got.x, got.y, got.z, got.w);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("r_x", want.x, got.x);
          compare_field("r_y", want.y, got.y);
          compare_field("r_z", want.z, got.z);
          compare_field("r_w", want.w, got.w);
        end
      end
      if (operand.valid && operand.ready) begin
        pending_results.push_back(predict_result(operand.command,
          {operand.q_x, operand.q_y, operand.q_z, operand.q_w},
          {operand.p_x, operand.p_y, operand.p_z, operand.p_w}));
      end
      in_flight <= pending_results.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// top of the quaternion core test: clock, reset, operand stimulus, result back-pressure, verdict
`timescale 1ns / 100ps

module testbench;
  import qpr_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int RANDOM_ITEMS = 1500;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 16;

  localparam logic signed [DATA_W-1:0] FIXED_ONE = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] COS_45    = 46341;

  typedef struct packed {
    logic  command;
    quat_t q;
    quat_t p;
  } operand_t;

  typedef enum {MIX_FULL, MIX_UNIT, MIX_MID, MIX_EDGE} value_mix_t;

  logic clk;
  logic rst;
  int   mismatches;
  int   in_flight;

  qpr_in_if  operand ();
  qpr_out_if result ();

  quaternion_product_and_rotate_core #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand),
    .result  (result)
  );

  quaternion_result_checker #(.FRAC_BITS(FRAC_BITS)) result_check (
    .clk        (clk),
    .rst        (rst),
    .operand    (operand),
    .result     (result),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, in_flight);
    $display("quaternion_product_and_rotate_core test failed");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] random_component(input value_mix_t mix);
    logic signed [DATA_W-1:0] v;
    case (mix)
      MIX_FULL: v = $urandom();
      MIX_UNIT: v = $signed($urandom_range(0, 2 * FIXED_ONE)) - FIXED_ONE;
      MIX_MID:  v = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      default: begin
        case ($urandom_range(0, 5))
          0:       v = Q_MAX;
          1:       v = Q_MIN;
          2:       v = '0;
          3:       v = FIXED_ONE;
          4:       v = -FIXED_ONE;
          default: v = -1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic quat_t random_quat(input value_mix_t mix);
    quat_t r;
    r.x = random_component(mix);
    r.y = random_component(mix);
    r.z = random_component(mix);
    r.w = random_component(mix);
    return r;
  endfunction

  // offer one operand transaction, optionally after a random gap
  task automatic send_operand(input operand_t item, input bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 99) < 4) begin
      operand.valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    operand.valid   <= 1'b1;
    operand.command <= item.command;
    operand.q_x     <= item.q.x;
    operand.q_y     <= item.q.y;
    operand.q_z     <= item.q.z;
    operand.q_w     <= item.q.w;
    operand.p_x     <= item.p.x;
    operand.p_y     <= item.p.y;
    operand.p_z     <= item.p.z;
    operand.p_w     <= item.p.w;
    do @(posedge clk); while (!operand.ready);
  endtask

  // result back-pressure: random stalls, two long hold-offs, one stall-free stretch
  initial begin
    int cycle;
    cycle = 0;
    result.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      if (cycle == 250 || cycle == 900) begin
        result.ready <= 1'b0;
        repeat (80) @(posedge clk);
        cycle += 80;
      end
      if (cycle >= 1200 && cycle < 1600) begin
        result.ready <= 1'b1;
      end else begin
        result.ready <= ($urandom_range(0, 99) >= 11);
      end
      @(posedge clk);
      cycle++;
    end
  end

  // reset, directed operands, random operands, drain, verdict
  initial begin
    operand_t   directed[$];
    operand_t   item;
    value_mix_t mix;

    rst = 1'b1;
    operand.valid = 1'b0;
    {operand.command, operand.q_x, operand.q_y, operand.q_z, operand.q_w,
     operand.p_x, operand.p_y, operand.p_z, operand.p_w} = '0;

    // products: zero, identity, extremes, floor truncation, basis units
    directed.push_back(operand_t'{CMD_PRODUCT, '{0, 0, 0, 0}, '{0, 0, 0, 0}});
    directed.push_back(operand_t'{CMD_PRODUCT, '{0, 0, 0, FIXED_ONE},
                                  '{32'sh1234_5678, -32'sh0765_4321, 32'sh7fff_0001, -5}});
    directed.push_back(operand_t'{CMD_PRODUCT, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX},
                                  '{Q_MAX, Q_MAX, Q_MAX, Q_MAX}});
    directed.push_back(operand_t'{CMD_PRODUCT, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN},
                                  '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}});
    directed.push_back(operand_t'{CMD_PRODUCT, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX},
                                  '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}});
    directed.push_back(operand_t'{CMD_PRODUCT, '{Q_MAX, Q_MIN, Q_MAX, Q_MIN},
                                  '{Q_MIN, Q_MAX, Q_MIN, Q_MAX}});
    directed.push_back(operand_t'{CMD_PRODUCT, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX},
                                  '{Q_MAX, Q_MIN, Q_MAX, Q_MIN}});
    directed.push_back(operand_t'{CMD_PRODUCT, '{-1, -1, -1, -1}, '{-1, -1, -1, -1}});
    directed.push_back(operand_t'{CMD_PRODUCT, '{1, -1, 1, -1}, '{-1, 1, 1, -1}});
    directed.push_back(operand_t'{CMD_PRODUCT, '{FIXED_ONE, 0, 0, 0}, '{0, FIXED_ONE, 0, 0}});
    // rotations: zero, identity, quarter turn, half turn, scaling, extremes
    directed.push_back(operand_t'{CMD_ROTATE, '{0, 0, 0, 0}, '{FIXED_ONE, -5, 7, Q_MAX}});
    directed.push_back(operand_t'{CMD_ROTATE, '{0, 0, 0, FIXED_ONE},
                                  '{3 * FIXED_ONE, -2 * FIXED_ONE, FIXED_ONE / 2, Q_MAX}});
    directed.push_back(operand_t'{CMD_ROTATE, '{0, 0, COS_45, COS_45},
                                  '{FIXED_ONE, 0, 0, Q_MIN}});
    directed.push_back(operand_t'{CMD_ROTATE, '{FIXED_ONE, 0, 0, 0},
                                  '{FIXED_ONE, FIXED_ONE, FIXED_ONE, 0}});
    directed.push_back(operand_t'{CMD_ROTATE, '{0, 0, 0, 2 * FIXED_ONE},
                                  '{FIXED_ONE, -FIXED_ONE, 3, -1}});
    directed.push_back(operand_t'{CMD_ROTATE, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN},
                                  '{FIXED_ONE, FIXED_ONE, FIXED_ONE, 0}});
    directed.push_back(operand_t'{CMD_ROTATE, '{Q_MIN, 0, 0, 0}, '{Q_MAX, Q_MIN, 1, -1}});
    directed.push_back(operand_t'{CMD_ROTATE, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX},
                                  '{Q_MAX, Q_MAX, Q_MAX, Q_MAX}});
    directed.push_back(operand_t'{CMD_ROTATE, '{0, 0, 0, FIXED_ONE},
                                  '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}});
    directed.push_back(operand_t'{CMD_ROTATE, '{Q_MIN, Q_MAX, Q_MIN, Q_MAX},
                                  '{-1, -1, -1, -1}});

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_operand(directed[i], 1'b1);
    end

    // random operands, with a gap-free stretch in the middle
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      mix = value_mix_t'($urandom_range(0, 3));
      item.command = ($urandom_range(0, 1) == 0) ? CMD_PRODUCT : CMD_ROTATE;
      item.q = random_quat(mix);
      item.p = random_quat(mix);
      send_operand(item, !(n >= 600 && n < 900));
    end
    operand.valid <= 1'b0;

    // let the last acceptance reach the checker, then drain
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("quaternion_product_and_rotate_core test passed");
    end else begin
      $display("quaternion_product_and_rotate_core test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/qpr_pkg.sv
rtl/qpr_in_if.sv
rtl/qpr_out_if.sv
rtl/qpr_hamilton.sv
rtl/quaternion_product_and_rotate_core.sv
dv/quaternion_result_checker.sv
dv/testbench.sv
